### rtl/core/kvls_pkg.sv
// ---------------------------------------------------------------------------
// kvls_pkg
// Shared types, constants and command/status structs for the vec3 keyframe
// linear-interpolation sampler.
// ---------------------------------------------------------------------------
package kvls_pkg;

  localparam int DEF_MAX_KEYS = 256;
  localparam int CNT_W        = 9;
  localparam int IDX_W        = 8;
  localparam int DW           = 32;
  localparam int FRAC_W       = 16;
  localparam int ALPHA_W      = FRAC_W + 1;
  localparam int QUO_W        = DW + FRAC_W + 1;

  // op codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                  op;
    logic [IDX_W-1:0]      key_index;
    logic signed [DW-1:0]  key_time;
    logic signed [DW-1:0]  value_x;
    logic signed [DW-1:0]  value_y;
    logic signed [DW-1:0]  value_z;
    logic signed [DW-1:0]  query_time;
  } in_word_t;

  typedef struct packed {
    logic signed [DW-1:0] out_x;
    logic signed [DW-1:0] out_y;
    logic signed [DW-1:0] out_z;
    logic                 table_empty;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_FIRST,
    ST_CHK_FIRST,
    ST_RD_LAST,
    ST_CHK_LAST,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  // result source select
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ENTRY,
    SRC_BLEND
  } src_t;

  // controller to datapath
  typedef struct packed {
    logic store_write;
    logic load_query;
    logic rd_first;
    logic rd_last;
    logic rd_scan;
    logic scan_next;
    logic div_start;
    logic div_step;
    logic mul_step;
    logic out_load;
    src_t src;
    logic empty_flag;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic le_first;
    logic ge_last;
    logic in_seg;
    logic scan_end;
    logic div_done;
    logic mul_done;
  } sts_t;

endpackage

### rtl/core/kvls_ctrl.sv
// ---------------------------------------------------------------------------
// kvls_ctrl
// Sequencing state machine: boundary checks, segment scan, division and
// blend steps, result hand-off.
// ---------------------------------------------------------------------------
module kvls_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_op,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  logic          empty_n,
  input  kvls_pkg::sts_t sts,
  output kvls_pkg::cmd_t cmd
);
  import kvls_pkg::*;

  state_t state, state_next;
  logic   out_full;
  logic   take;

  assign take      = in_valid && !in_stall;
  // accept while idle; a pending result must be cleared before a new query
  assign in_stall  = (state != ST_IDLE) || (out_full && in_op == OP_QUERY);
  assign out_valid = out_full;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && in_op == OP_QUERY) begin
          state_next = empty_n ? ST_RD_FIRST : ST_OUT;
        end
      end
      ST_RD_FIRST:  state_next = ST_CHK_FIRST;
      ST_CHK_FIRST: state_next = sts.le_first ? ST_OUT : ST_RD_LAST;
      ST_RD_LAST:   state_next = ST_CHK_LAST;
      ST_CHK_LAST:  state_next = sts.ge_last ? ST_OUT : ST_SCAN_RD;
      ST_SCAN_RD:   state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (sts.in_seg) begin
          state_next = ST_DIV;
        end else if (sts.scan_end) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_DIV:  state_next = sts.div_done ? ST_MUL : ST_DIV;
      ST_MUL:  state_next = sts.mul_done ? ST_OUT : ST_MUL;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    cmd.src = SRC_ZERO;
    cmd.store_write = take && in_op == OP_WRITE;
    cmd.load_query  = take && in_op == OP_QUERY;
    cmd.empty_flag  = !empty_n;
    case (state)
      ST_RD_FIRST:  cmd.rd_first = 1'b1;
      ST_CHK_FIRST: begin
        cmd.src = SRC_ENTRY;
        cmd.out_load = sts.le_first;
      end
      ST_RD_LAST:   cmd.rd_last = 1'b1;
      ST_CHK_LAST: begin
        cmd.src = SRC_ENTRY;
        cmd.out_load = sts.ge_last;
      end
      ST_SCAN_RD:   cmd.rd_scan = 1'b1;
      ST_SCAN_CHK: begin
        cmd.div_start = sts.in_seg;
        cmd.scan_next = !sts.in_seg;
        cmd.out_load  = !sts.in_seg && sts.scan_end;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cmd.src      = SRC_BLEND;
        cmd.out_load = sts.mul_done;
      end
      ST_OUT:  cmd.out_load = !empty_n;
      default: ;
    endcase
  end

  // state and output-full flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_full <= 1'b1;
      end else if (out_full && !out_stall) begin
        out_full <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !take) else $error("item taken while busy");
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !out_full || !out_stall || state != ST_IDLE)
    else $error("result overwritten");
  a_out_after: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |=> state == ST_IDLE) else $error("bad exit");
`endif

endmodule

### rtl/core/kvls_dp.sv
// ---------------------------------------------------------------------------
// kvls_dp
// Key stores, scan pointer, restoring divider for alpha and shift-add
// blend of the three components.
// ---------------------------------------------------------------------------
module kvls_dp #(
  parameter int MAX_KEYS = kvls_pkg::DEF_MAX_KEYS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [kvls_pkg::CNT_W-1:0] key_count,
  input  kvls_pkg::in_word_t in_word,
  input  kvls_pkg::cmd_t     cmd,
  output kvls_pkg::sts_t     sts,
  output logic               empty_n,
  output kvls_pkg::out_word_t out_word
);
  import kvls_pkg::*;

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int PW = AW + 1;

  logic [DW-1:0] time_mem [MAX_KEYS];
  logic [DW-1:0] x_mem [MAX_KEYS];
  logic [DW-1:0] y_mem [MAX_KEYS];
  logic [DW-1:0] z_mem [MAX_KEYS];

  logic [PW-1:0] n_keys;
  logic [PW-1:0] ptr;
  logic [AW-1:0] rd_addr;
  logic          rd_sel;   // second read of a segment pair
  logic signed [DW-1:0] rd_t, rd_x, rd_y, rd_z;
  logic signed [DW-1:0] q_t;
  logic signed [DW-1:0] t0, x0, y0, z0;
  logic                 have_t0;
  logic signed [DW:0]   num_diff, den_diff;

  // divider
  logic [QUO_W-1:0] div_num;
  logic [DW:0]      div_den;
  logic [DW+1:0]    div_rem;
  logic [QUO_W-1:0] div_quo;
  logic [5:0]       div_cnt;
  logic [DW+1:0]    rem_sh;
  logic [DW+1:0]    rem_sub;

  // blend, shift-add over alpha bits
  logic [ALPHA_W-1:0] alpha;
  logic [4:0]         mul_cnt;
  logic signed [DW:0] dx, dy, dz;
  logic signed [DW+ALPHA_W+1:0] px, py, pz;
  logic signed [DW+ALPHA_W+1:0] rx, ry, rz;

  assign n_keys  = (int'(key_count) > MAX_KEYS) ? PW'(MAX_KEYS) : PW'(key_count);
  assign empty_n = n_keys != '0;

  // store writes, one port
  always_ff @(posedge clk) begin
    if (cmd.store_write && int'(in_word.key_index) < MAX_KEYS) begin
      time_mem[AW'(in_word.key_index)] <= in_word.key_time;
      x_mem[AW'(in_word.key_index)]    <= in_word.value_x;
      y_mem[AW'(in_word.key_index)]    <= in_word.value_y;
      z_mem[AW'(in_word.key_index)]    <= in_word.value_z;
    end
  end

  // read address
  always_comb begin
    rd_addr = '0;
    if (cmd.rd_last) begin
      rd_addr = AW'(n_keys - PW'(1));
    end else if (cmd.rd_scan) begin
      rd_addr = ptr[AW-1:0];
    end else if (cmd.rd_first) begin
      rd_addr = '0;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_t <= time_mem[rd_addr];
    rd_x <= x_mem[rd_addr];
    rd_y <= y_mem[rd_addr];
    rd_z <= z_mem[rd_addr];
  end

  // query time and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_t     <= in_word.query_time;
      ptr     <= '0;
      have_t0 <= 1'b0;
    end else if (cmd.scan_next) begin
      t0      <= rd_t;
      x0      <= rd_x;
      y0      <= rd_y;
      z0      <= rd_z;
      have_t0 <= 1'b1;
      ptr     <= ptr + PW'(1);
    end
  end

  assign rd_sel       = have_t0;
  assign sts.le_first = q_t <= rd_t;
  assign sts.ge_last  = q_t >= rd_t;
  assign sts.in_seg   = rd_sel && (q_t >= t0) && (q_t <= rd_t);
  assign sts.scan_end = ptr + PW'(1) >= n_keys;

  assign num_diff = {q_t[DW-1], q_t} - {t0[DW-1], t0};
  assign den_diff = {rd_t[DW-1], rd_t} - {t0[DW-1], t0};

  // restoring divider, one quotient bit a cycle
  assign rem_sh  = {div_rem[DW:0], div_num[QUO_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_den};
  assign sts.div_done = div_cnt == 6'(QUO_W);

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_num <= {num_diff[DW-1:0], {FRAC_W{1'b0}}, 1'b0} >> 1;
      div_den <= den_diff;
      div_rem <= '0;
      div_quo <= '0;
      div_cnt <= '0;
      dx <= {rd_x[DW-1], rd_x} - {x0[DW-1], x0};
      dy <= {rd_y[DW-1], rd_y} - {y0[DW-1], y0};
      dz <= {rd_z[DW-1], rd_z} - {z0[DW-1], z0};
    end else if (cmd.div_step && !sts.div_done) begin
      div_num <= div_num << 1;
      if (!rem_sub[DW+1]) begin
        div_rem <= rem_sub;
        div_quo <= {div_quo[QUO_W-2:0], 1'b1};
      end else begin
        div_rem <= rem_sh;
        div_quo <= {div_quo[QUO_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 6'd1;
    end
  end

  // zero-length segment repaired to alpha 0
  assign alpha = (div_den == '0) ? '0 : div_quo[ALPHA_W-1:0];

  // shift-add multiply, one alpha bit a cycle
  assign sts.mul_done = mul_cnt == 5'(ALPHA_W);
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      mul_cnt <= '0;
      px <= '0;
      py <= '0;
      pz <= '0;
    end else if (cmd.mul_step && !sts.mul_done) begin
      if (alpha[mul_cnt]) begin
        px <= px + ($signed({{(ALPHA_W+1){dx[DW]}}, dx}) <<< mul_cnt);
        py <= py + ($signed({{(ALPHA_W+1){dy[DW]}}, dy}) <<< mul_cnt);
        pz <= pz + ($signed({{(ALPHA_W+1){dz[DW]}}, dz}) <<< mul_cnt);
      end
      mul_cnt <= mul_cnt + 5'd1;
    end
  end

  // round half up, then add base
  assign rx = (px + (DW+ALPHA_W+2)'(32768)) >>> FRAC_W;
  assign ry = (py + (DW+ALPHA_W+2)'(32768)) >>> FRAC_W;
  assign rz = (pz + (DW+ALPHA_W+2)'(32768)) >>> FRAC_W;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.table_empty <= cmd.empty_flag;
      case (cmd.src)
        SRC_ENTRY: begin
          out_word.out_x <= rd_x;
          out_word.out_y <= rd_y;
          out_word.out_z <= rd_z;
        end
        SRC_BLEND: begin
          out_word.out_x <= x0 + rx[DW-1:0];
          out_word.out_y <= y0 + ry[DW-1:0];
          out_word.out_z <= z0 + rz[DW-1:0];
        end
        default: begin
          out_word.out_x <= '0;
          out_word.out_y <= '0;
          out_word.out_z <= '0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_alpha_max: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_step |-> alpha <= ALPHA_W'(65536)) else $error("alpha above one");
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_scan |-> ptr < n_keys) else $error("scan beyond count");
  a_div_den: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !div_den[DW]) else $error("negative segment length");
`endif

endmodule

### rtl/core/keyframe_vec3_lerp_sampler.sv
// ---------------------------------------------------------------------------
// keyframe_vec3_lerp_sampler
// Vec3 keyframe sampler with linear interpolation between bracketing keys.
// ---------------------------------------------------------------------------
// channel | signals                       | word
// in      | in_valid, in_stall, in_word   | write key or query
// out     | out_valid, out_stall, out_word| sampled x, y, z, empty flag
// cfg     | cfg_we, cfg_wdata             | key_count
//
// a write word is stored when it is taken; a query runs the boundary checks
// against the first and last keys, then the segment scan, the divider and
// the multiply; after the result is loaded the controller returns to idle
// through ST_OUT before it takes the next word.
// the key stores have one read port, which sets the scan rate.
// synchronous reset clears the controller and key_count; stores stay unset.
// a query is held off while an earlier result still waits.
module keyframe_vec3_lerp_sampler #(
  parameter int MAX_KEYS = kvls_pkg::DEF_MAX_KEYS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  kvls_pkg::in_word_t          in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output kvls_pkg::out_word_t         out_word,
  input  logic                        cfg_we,
  input  logic [kvls_pkg::CNT_W-1:0]  cfg_wdata
);
  import kvls_pkg::*;

  logic [CNT_W-1:0] key_count;
  cmd_t cmd;
  sts_t sts;
  logic empty_n;

  // key count register
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cfg_we) begin
      key_count <= cfg_wdata;
    end
  end

  kvls_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_op(in_word.op),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .empty_n(empty_n), .sts(sts), .cmd(cmd)
  );

  kvls_dp #(.MAX_KEYS(MAX_KEYS)) u_dp (
    .clk(clk), .rst(rst), .key_count(key_count), .in_word(in_word),
    .cmd(cmd), .sts(sts), .empty_n(empty_n), .out_word(out_word)
  );

endmodule
